### design/ccss_pkg.sv
// Shared types and constants for the C comment and string stripper.
// Used by ccss_lexer, ccss_out_fifo and c_comment_string_stripper_core.
package ccss_pkg;

  typedef enum logic [2:0] {
    MODE_CODE   = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_STRING = 3'd3,
    MODE_CHAR   = 3'd4
  } lex_mode_e;

  typedef struct packed {
    lex_mode_e  mode;
    logic       held_slash;
    logic       star_seen;
    logic       escape_pending;
  } lex_state_t;

  // Up to two kept bytes caused by one input beat.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] char0;
    logic [7:0] char1;
  } lex_result_t;

  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChStar      = 8'h2a;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5c;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

endpackage

### design/ccss_lexer.sv
// Lexer state register and per-byte mode update for the stripper.
// Depends on ccss_pkg.
module ccss_lexer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  output ccss_pkg::lex_result_t result_o
);
  import ccss_pkg::*;

  lex_state_t  state_q, state_d;
  lex_result_t res;

  function automatic lex_result_t emit(lex_result_t r, logic [7:0] ch);
    lex_result_t o;
    o = r;
    if (r.count == 2'd0) begin
      o.char0 = ch;
      o.count = 2'd1;
    end else if (r.count == 2'd1) begin
      o.char1 = ch;
      o.count = 2'd2;
    end
    return o;
  endfunction

  always_comb begin
    logic [7:0] close_ch;
    state_d   = state_q;
    res.count = 2'd0;
    res.char0 = 8'h00;
    res.char1 = 8'h00;
    close_ch  = (state_q.mode == MODE_STRING) ? ChDquote : ChSquote;
    unique case (state_q.mode) inside
      MODE_LINE: begin
        if (char_i == ChNewline) begin
          res          = emit(res, ChNewline);
          state_d.mode = MODE_CODE;
        end
      end
      MODE_BLOCK: begin
        if (char_i == ChNewline) res = emit(res, ChNewline);
        if (state_q.star_seen && char_i == ChSlash) begin
          state_d.mode      = MODE_CODE;
          state_d.star_seen = 1'b0;
        end else begin
          state_d.star_seen = (char_i == ChStar);
        end
      end
      MODE_STRING, MODE_CHAR: begin
        if (char_i == ChNewline) res = emit(res, ChNewline);
        if (state_q.escape_pending) begin
          state_d.escape_pending = 1'b0;
        end else if (char_i == ChBackslash) begin
          state_d.escape_pending = 1'b1;
        end else if (char_i == close_ch) begin
          state_d.mode = MODE_CODE;
        end
      end
      default: begin
        state_d.mode = MODE_CODE;
        if (state_q.held_slash && char_i == ChSlash) begin
          state_d.held_slash = 1'b0;
          state_d.mode       = MODE_LINE;
        end else if (state_q.held_slash && char_i == ChStar) begin
          state_d.held_slash = 1'b0;
          state_d.mode       = MODE_BLOCK;
          state_d.star_seen  = 1'b0;
        end else begin
          if (state_q.held_slash) begin
            state_d.held_slash = 1'b0;
            res                = emit(res, ChSlash);
          end
          if (char_i == ChSlash) begin
            state_d.held_slash = 1'b1;
          end else if (char_i == ChDquote) begin
            state_d.mode           = MODE_STRING;
            state_d.escape_pending = 1'b0;
          end else if (char_i == ChSquote) begin
            state_d.mode           = MODE_CHAR;
            state_d.escape_pending = 1'b0;
          end else begin
            res = emit(res, char_i);
          end
        end
      end
    endcase
    if (last_i) begin
      if (state_d.held_slash) res = emit(res, ChSlash);
      state_d.mode           = MODE_CODE;
      state_d.held_slash     = 1'b0;
      state_d.star_seen      = 1'b0;
      state_d.escape_pending = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode           <= MODE_CODE;
      state_q.held_slash     <= 1'b0;
      state_q.star_seen      <= 1'b0;
      state_q.escape_pending <= 1'b0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign result_o = res;

  a_star_in_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.star_seen |-> state_q.mode == MODE_BLOCK)
    else $error("star flag outside block comment");
  a_held_in_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held_slash |-> state_q.mode == MODE_CODE)
    else $error("held slash outside code mode");
  a_esc_in_quote : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.escape_pending |-> (state_q.mode == MODE_STRING || state_q.mode == MODE_CHAR))
    else $error("escape flag outside quoted text");
  a_last_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_i |=> state_q.mode == MODE_CODE && !state_q.held_slash)
    else $error("state not reset after last beat");

endmodule

### design/ccss_out_fifo.sv
// Result queue: up to two bytes in per beat, one out per cycle when ready.
// Depends on ccss_pkg.
module ccss_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ccss_pkg::lex_result_t result_i,
  output logic                  room_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);
  import ccss_pkg::*;

  logic [8:0]      mem_q [FifoDepth];
  logic [PtrW-1:0] head_q, tail_q, head_d, tail_d, tail_nx;
  logic [CntW-1:0] count_q, count_d, push_n;
  logic            pop;

  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign push_n  = push_i ? CntW'(result_i.count) : '0;
  assign tail_nx = tail_q + PtrW'(1);
  assign head_d  = pop ? head_q + PtrW'(1) : head_q;
  assign tail_d  = tail_q + PtrW'(push_n);
  assign count_d = count_q + push_n - CntW'(pop);
  assign room_o  = count_q <= CntW'(FifoDepth - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && result_i.count != 2'd0) begin
      mem_q[tail_q] <= {result_i.count == 2'd1, result_i.char0};
    end
    if (push_i && result_i.count == 2'd2) begin
      mem_q[tail_nx] <= {1'b1, result_i.char1};
    end
  end

  assign m_axis_tvalid_o = count_q != '0;
  assign m_axis_tdata_o  = mem_q[head_q][7:0];
  assign m_axis_tlast_o  = mem_q[head_q][8];

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue overflow");
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && result_i.count == 2'd2 |=> count_q >= CntW'(2 - 1))
    else $error("two-byte push lost");
  a_ptr_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 || count_q == CntW'(FifoDepth) || head_q != tail_q)
    else $error("pointers disagree with count");

endmodule

### design/c_comment_string_stripper_core.sv
// Top level of the C comment and string stripper.
// Depends on ccss_pkg, ccss_lexer and ccss_out_fifo.
//
// Takes one source byte per beat on the slave stream and returns the kept
// bytes on the master stream, one per beat; tlast on the master side marks
// the last kept byte caused by an input beat, tlast on the slave side marks
// the final byte of a source. A beat is accepted every cycle while the
// four-entry result queue holds at most two bytes; kept bytes leave at one
// per cycle while the master is ready, after the input register and the
// result queue. A byte that yields two results (a released slash plus the
// byte) needs two output beats, so the output port sets the sustained rate.
module c_comment_string_stripper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_char
  input  logic       s_axis_tlast_i,   // is_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o    // run_last
);
  import ccss_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_last_q;
  logic        room;
  logic        advance;
  lex_result_t result;

  assign advance         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  ccss_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .result_o  (result)
  );

  ccss_out_fifo u_out_fifo (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (advance),
    .result_i        (result),
    .room_o          (room),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
